[hw/rtl/point_distance_and_travel_time_macros.svh]
// ----------------------------------------------------------------------------
// Point distance and travel time: assertion macros
// Shared property shorthands for the checker of this block.
// ----------------------------------------------------------------------------
`ifndef POINT_DISTANCE_AND_TRAVEL_TIME_MACROS_SVH
`define POINT_DISTANCE_AND_TRAVEL_TIME_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define PDT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define PDT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/pdt_pkg.sv]
// ----------------------------------------------------------------------------
// Point distance and travel time: package
// Field widths, register indexes and default parameter values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdt_pkg;

   localparam int FRAC_BITS_DEF  = 8;
   localparam int COORD_BITS_DEF = 24;

   localparam int CFG_W   = 16;   // acceleration, top speed, start speed
   localparam int DIST_W  = 25;   // distance result
   localparam int TIME_W  = 32;   // time result

   // Register map of the configuration port.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_SPEED = 1'b1;
   localparam logic [CFG_W-1:0]     CFG_RESET     = 16'd256;

   // Internal widths that follow from the fixed field widths.
   localparam int RAD1_W   = 2 * DIST_W;            // distance radicand
   localparam int TWO_AS_W = DIST_W + CFG_W + 1;    // 2*a*d
   localparam int SQ_W     = 2 * CFG_W;             // u*u, v*v, a*v
   localparam int ROOT2_W  = (TWO_AS_W + 2) / 2;    // root of u*u + 2*a*d
   localparam int RAD2_W   = 2 * ROOT2_W;
   localparam int DEN_W    = SQ_W + 1;              // divisor
   localparam int NUM_BASE_W = TWO_AS_W + 1;        // dividend before scaling

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

endpackage

`default_nettype wire

[hw/rtl/point_distance_and_travel_time.sv]
// Throughput: one request per cycle; the pipeline holds only while its skid entry is full.
// Depth is set by the distance root (25 stages), the ramp root (22 stages) and the
// divider (43 + FRAC_BITS stages), plus six arithmetic stages and the output register.
// Synchronous reset empties the pipeline and sets both registers to 256.
// ----------------------------------------------------------------------------
// Point distance and travel time
// Straight-line distance and trapezoidal-profile travel time per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_distance_and_travel_time #(
   parameter int FRAC_BITS  = pdt_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = pdt_pkg::COORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pdt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pdt_pkg::CFG_W-1:0]       csr_data,

   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [COORD_BITS-1:0]    req_start_x,
   input  wire logic signed [COORD_BITS-1:0]    req_start_y,
   input  wire logic signed [COORD_BITS-1:0]    req_goal_x,
   input  wire logic signed [COORD_BITS-1:0]    req_goal_y,
   input  wire logic [pdt_pkg::CFG_W-1:0]       req_start_speed,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [pdt_pkg::DIST_W-1:0]           rsp_trip_distance,
   output logic [pdt_pkg::TIME_W-1:0]           rsp_trip_time,
   output logic                                 rsp_reaches_top_speed,
   output logic                                 rsp_setting_error,
   output logic                                 rsp_time_saturated
);

   import pdt_pkg::*;

   localparam int SQW  = 2 * COORD_BITS;
   localparam int SUMW = (SQW + 1 > RAD1_W + 1) ? SQW + 1 : RAD1_W + 1;
   localparam int NUMW = NUM_BASE_W + FRAC_BITS;

   typedef struct packed {
      logic              dsat;
      logic [CFG_W-1:0]  u;
   } s1side_type;

   typedef struct packed {
      logic [DIST_W-1:0]   d;
      logic [CFG_W-1:0]    u;
      logic                err;
      logic                cruise;
      logic [TWO_AS_W-1:0] two_as;
      logic [SQ_W-1:0]     gap2;
      logic [SQ_W-1:0]     av;
   } s2side_type;

   typedef struct packed {
      logic [DIST_W-1:0] d;
      logic              err;
      logic              cruise;
      logic              zero;
   } dvside_type;

   typedef struct packed {
      logic [DIST_W-1:0] trip_dist;
      logic [TIME_W-1:0] tim;
      logic              cruise;
      logic              err;
      logic              sat;
   } rsp_type;

   // ---------------------------------------------------------------- registers
   logic [CFG_W-1:0] accel_ff;
   logic [CFG_W-1:0] vtop_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= CFG_RESET;
         vtop_ff  <= CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ACCEL:     accel_ff <= csr_data;
            CSR_TOP_SPEED: vtop_ff  <= csr_data;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow
   logic    advance;
   logic    skid_vld_ff;
   logic    rsp_vld_ff;
   rsp_type rsp_data_ff;
   rsp_type skid_data_ff;

   assign advance   = ~skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // ---------------------------------------------------------------- stage 1
   logic signed [COORD_BITS:0] diff_x;
   logic signed [COORD_BITS:0] diff_y;
   logic [COORD_BITS-1:0]      dx_in;
   logic [COORD_BITS-1:0]      dy_in;
   logic                       s1_vld_ff;
   logic [COORD_BITS-1:0]      s1_dx_ff;
   logic [COORD_BITS-1:0]      s1_dy_ff;
   logic [CFG_W-1:0]           s1_u_ff;

   always_comb begin
      diff_x = {req_goal_x[COORD_BITS-1], req_goal_x}
             - {req_start_x[COORD_BITS-1], req_start_x};
      diff_y = {req_goal_y[COORD_BITS-1], req_goal_y}
             - {req_start_y[COORD_BITS-1], req_start_y};
      dx_in  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
      dy_in  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dx_ff <= dx_in;
         s1_dy_ff <= dy_in;
         s1_u_ff  <= req_start_speed;
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic [SQW-1:0]   dx_ext;
   logic [SQW-1:0]   dy_ext;
   logic             s2_vld_ff;
   logic [SQW-1:0]   s2_dx2_ff;
   logic [SQW-1:0]   s2_dy2_ff;
   logic [CFG_W-1:0] s2_u_ff;

   assign dx_ext = SQW'(s1_dx_ff);
   assign dy_ext = SQW'(s1_dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_dx2_ff <= dx_ext * dx_ext;
         s2_dy2_ff <= dy_ext * dy_ext;
         s2_u_ff   <= s1_u_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic [SUMW-1:0]   sum_in;
   logic              s3_vld_ff;
   logic [RAD1_W-1:0] s3_rad_ff;
   s1side_type        s3_side_ff;

   assign sum_in = SUMW'(s2_dx2_ff) + SUMW'(s2_dy2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // A sum of 2^50 or more has a root beyond the distance range.
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_rad_ff       <= sum_in[RAD1_W-1:0];
         s3_side_ff.dsat <= |sum_in[SUMW-1:RAD1_W];
         s3_side_ff.u    <= s2_u_ff;
      end
   end

   // ---------------------------------------------------------------- distance root
   logic              r1_vld;
   logic [DIST_W-1:0] r1_root;
   s1side_type        r1_side;

   pdt_isqrt #(
      .RW     (DIST_W),
      .SIDE_W ($bits(s1side_type))
   ) u_dist_root (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s3_vld_ff),
      .in_radicand (s3_rad_ff),
      .in_side     (s3_side_ff),
      .out_valid   (r1_vld),
      .out_root    (r1_root),
      .out_side    (r1_side)
   );

   // ---------------------------------------------------------------- stage 4
   logic [DIST_W-1:0]   d_in;
   logic [TWO_AS_W-1:0] a_ext;
   logic [TWO_AS_W-1:0] d_ext;
   logic                s4_vld_ff;
   logic [DIST_W-1:0]   s4_d_ff;
   logic [CFG_W-1:0]    s4_u_ff;
   logic                s4_err_ff;
   logic [TWO_AS_W-1:0] s4_two_as_ff;
   logic [SQ_W-1:0]     s4_uu_ff;
   logic [SQ_W-1:0]     s4_vv_ff;
   logic [SQ_W-1:0]     s4_av_ff;
   logic [CFG_W-1:0]    s4_gap_ff;

   assign d_in  = r1_side.dsat ? DIST_MAX : r1_root;
   assign a_ext = TWO_AS_W'(accel_ff);
   assign d_ext = TWO_AS_W'(d_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s4_vld_ff <= r1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_d_ff      <= d_in;
         s4_u_ff      <= r1_side.u;
         s4_err_ff    <= (accel_ff == '0) || (vtop_ff == '0) || (r1_side.u > vtop_ff);
         s4_two_as_ff <= (a_ext * d_ext) << 1;
         s4_uu_ff     <= SQ_W'(r1_side.u) * SQ_W'(r1_side.u);
         s4_vv_ff     <= SQ_W'(vtop_ff) * SQ_W'(vtop_ff);
         s4_av_ff     <= SQ_W'(accel_ff) * SQ_W'(vtop_ff);
         s4_gap_ff    <= vtop_ff - r1_side.u;
      end
   end

   // ---------------------------------------------------------------- stage 5
   logic [RAD2_W-1:0] rad2_in;
   logic              s5_vld_ff;
   logic [RAD2_W-1:0] s5_rad_ff;
   s2side_type        s5_side_ff;

   assign rad2_in = RAD2_W'(s4_uu_ff) + RAD2_W'(s4_two_as_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (advance) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   // Top speed is reached when v*v falls short of u*u + 2*a*d.
   always_ff @(posedge clock) begin
      if (advance) begin
         s5_rad_ff         <= rad2_in;
         s5_side_ff.d      <= s4_d_ff;
         s5_side_ff.u      <= s4_u_ff;
         s5_side_ff.err    <= s4_err_ff;
         s5_side_ff.cruise <= RAD2_W'(s4_vv_ff) < rad2_in;
         s5_side_ff.two_as <= s4_two_as_ff;
         s5_side_ff.gap2   <= SQ_W'(s4_gap_ff) * SQ_W'(s4_gap_ff);
         s5_side_ff.av     <= s4_av_ff;
      end
   end

   // ---------------------------------------------------------------- ramp root
   logic               r2_vld;
   logic [ROOT2_W-1:0] r2_root;
   s2side_type         r2_side;

   pdt_isqrt #(
      .RW     (ROOT2_W),
      .SIDE_W ($bits(s2side_type))
   ) u_ramp_root (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s5_vld_ff),
      .in_radicand (s5_rad_ff),
      .in_side     (s5_side_ff),
      .out_valid   (r2_vld),
      .out_root    (r2_root),
      .out_side    (r2_side)
   );

   // ---------------------------------------------------------------- stage 6
   logic [NUMW-1:0]  num_in;
   logic [DEN_W-1:0] den_in;
   logic             s6_vld_ff;
   logic [NUMW-1:0]  s6_num_ff;
   logic [DEN_W-1:0] s6_den_ff;
   dvside_type       s6_side_ff;

   always_comb begin
      if (r2_side.cruise) begin
         num_in = (NUMW'(r2_side.two_as) + NUMW'(r2_side.gap2)) << FRAC_BITS;
         den_in = {r2_side.av, 1'b0};
      end else begin
         num_in = NUMW'({r2_side.d, 1'b0}) << FRAC_BITS;
         den_in = DEN_W'(r2_side.u) + DEN_W'(r2_root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (advance) begin
         s6_vld_ff <= r2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_num_ff         <= num_in;
         s6_den_ff         <= den_in;
         s6_side_ff.d      <= r2_side.d;
         s6_side_ff.err    <= r2_side.err;
         s6_side_ff.cruise <= r2_side.cruise;
         s6_side_ff.zero   <= (r2_side.d == '0);
      end
   end

   // ---------------------------------------------------------------- divider
   logic            dv_vld;
   logic [NUMW-1:0] dv_quo;
   dvside_type      dv_side;

   pdt_divide #(
      .NW     (NUMW),
      .DW     (DEN_W),
      .SIDE_W ($bits(dvside_type))
   ) u_time_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s6_vld_ff),
      .in_num    (s6_num_ff),
      .in_den    (s6_den_ff),
      .in_side   (s6_side_ff),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // ---------------------------------------------------------------- result
   rsp_type result_in;
   logic    over;

   always_comb begin
      over                = |dv_quo[NUMW-1:TIME_W];
      result_in.trip_dist = dv_side.d;
      result_in.err       = dv_side.err;
      if (dv_side.err || dv_side.zero) begin
         result_in.tim    = '0;
         result_in.cruise = 1'b0;
         result_in.sat    = 1'b0;
      end else begin
         result_in.tim    = over ? TIME_MAX : dv_quo[TIME_W-1:0];
         result_in.cruise = dv_side.cruise;
         result_in.sat    = over;
      end
   end

   // Output register with one skid entry; the pipeline freezes only while the
   // skid entry is occupied.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (!rsp_stall) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (dv_vld) begin
         if (rsp_vld_ff && rsp_stall) begin
            skid_vld_ff <= 1'b1;
         end else begin
            rsp_vld_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (!rsp_stall) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (dv_vld) begin
         if (rsp_vld_ff && rsp_stall) begin
            skid_data_ff <= result_in;
         end else begin
            rsp_data_ff <= result_in;
         end
      end
   end

   assign rsp_valid             = rsp_vld_ff;
   assign rsp_trip_distance     = rsp_data_ff.trip_dist;
   assign rsp_trip_time         = rsp_data_ff.tim;
   assign rsp_reaches_top_speed = rsp_data_ff.cruise;
   assign rsp_setting_error     = rsp_data_ff.err;
   assign rsp_time_saturated    = rsp_data_ff.sat;

endmodule

`default_nettype wire

[hw/rtl/pdt_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, truncating; a sideband word travels with each value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdt_isqrt #(
   parameter int RW     = 25,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire logic [2*RW-1:0]   in_radicand,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [RW-1:0]          out_root,
   output logic [SIDE_W-1:0]      out_side
);

   logic              vld_ff  [RW];
   logic [RW+1:0]     rem_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [2*RW-1:0]   rad_ff  [RW];
   logic [SIDE_W-1:0] side_ff [RW];

   logic              p_vld  [RW];
   logic [RW+1:0]     p_rem  [RW];
   logic [RW-1:0]     p_root [RW];
   logic [2*RW-1:0]   p_rad  [RW];
   logic [SIDE_W-1:0] p_side [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW+1:0] trial;
      logic [RW+1:0] test;
      logic          take;
      logic [RW+1:0] rem_in;
      logic [RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign p_vld[k]  = in_valid;
         assign p_rem[k]  = '0;
         assign p_root[k] = '0;
         assign p_rad[k]  = in_radicand;
         assign p_side[k] = in_side;
      end else begin : g_next
         assign p_vld[k]  = vld_ff[k-1];
         assign p_rem[k]  = rem_ff[k-1];
         assign p_root[k] = root_ff[k-1];
         assign p_rad[k]  = rad_ff[k-1];
         assign p_side[k] = side_ff[k-1];
      end

      // Bring down the next two radicand bits and try the root bit.
      assign trial   = {p_rem[k][RW-1:0], p_rad[k][2*RW-1 -: 2]};
      assign test    = {p_root[k], 2'b01};
      assign take    = (trial >= test);
      assign rem_in  = take ? (trial - test) : trial;
      assign root_in = {p_root[k][RW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= p_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= p_rad[k] << 2;
            side_ff[k] <= p_side[k];
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

[hw/rtl/pdt_divide.sv]
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with a sideband word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdt_divide #(
   parameter int NW     = 51,
   parameter int DW     = 33,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire logic [NW-1:0]     in_num,
   input  wire logic [DW-1:0]     in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NW-1:0]          out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   logic              vld_ff  [NW];
   logic [DW-1:0]     rem_ff  [NW];
   logic [NW-1:0]     num_ff  [NW];
   logic [DW-1:0]     den_ff  [NW];
   logic [SIDE_W-1:0] side_ff [NW];

   logic              p_vld  [NW];
   logic [DW-1:0]     p_rem  [NW];
   logic [NW-1:0]     p_num  [NW];
   logic [DW-1:0]     p_den  [NW];
   logic [SIDE_W-1:0] p_side [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] num_in;

      if (k == 0) begin : g_first
         assign p_vld[k]  = in_valid;
         assign p_rem[k]  = '0;
         assign p_num[k]  = in_num;
         assign p_den[k]  = in_den;
         assign p_side[k] = in_side;
      end else begin : g_next
         assign p_vld[k]  = vld_ff[k-1];
         assign p_rem[k]  = rem_ff[k-1];
         assign p_num[k]  = num_ff[k-1];
         assign p_den[k]  = den_ff[k-1];
         assign p_side[k] = side_ff[k-1];
      end

      // The dividend shifts out at the top while quotient bits shift in below.
      assign trial  = {p_rem[k], p_num[k][NW-1]};
      assign diff   = trial - {1'b0, p_den[k]};
      assign take   = (trial >= {1'b0, p_den[k]});
      assign rem_in = take ? diff[DW-1:0] : trial[DW-1:0];
      assign num_in = {p_num[k][NW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= p_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= num_in;
            den_ff[k]  <= p_den[k];
            side_ff[k] <= p_side[k];
         end
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quo   = num_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

`default_nettype wire

[hw/rtl/pdt_checker.sv]
// ----------------------------------------------------------------------------
// Point distance and travel time: port checker
// Watches the result port and the request back-pressure over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "point_distance_and_travel_time_macros.svh"

module pdt_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [pdt_pkg::DIST_W-1:0] rsp_trip_distance,
   input wire logic [pdt_pkg::TIME_W-1:0] rsp_trip_time,
   input wire logic                       rsp_reaches_top_speed,
   input wire logic                       rsp_setting_error,
   input wire logic                       rsp_time_saturated
);

   import pdt_pkg::*;

   `PDT_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")

   `PDT_ASSERT_NOW(a_err_clean, rsp_valid && rsp_setting_error, (rsp_trip_time == '0) && !rsp_reaches_top_speed && !rsp_time_saturated, "setting error with time")

   `PDT_ASSERT_NOW(a_sat_max, rsp_valid && rsp_time_saturated, (rsp_trip_time == TIME_MAX) && !rsp_setting_error, "saturation flag without maximum time")

   `PDT_ASSERT_NOW(a_zero_trip, rsp_valid && (rsp_trip_distance == '0), (rsp_trip_time == '0) && !rsp_reaches_top_speed, "zero distance with nonzero time")

   `PDT_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid, "request stalled with empty output")

endmodule

bind point_distance_and_travel_time pdt_checker u_pdt_checker (.*);

`default_nettype wire
